>>> rtl/core/sofd_pkg.sv
`timescale 1ns / 1ps
package sofd_pkg;

  localparam int NumPhases = 6;
  localparam int DivBits   = 17;   // quotient bits, top bit flags q >= 65536
  localparam int MagW      = 37;   // magnitude of numerator / denominator
  localparam int SumW      = 38;   // signed numerator / denominator
  localparam int RemW      = MagW + 13;
  localparam int CmpW      = MagW + 1 + DivBits;

  localparam logic [17:0] CoefOne    = 18'd65536;
  localparam logic [17:0] CoefTwo    = 18'd131072;
  localparam logic [17:0] CoefSqrt3  = 18'd113512;
  localparam logic [17:0] CoefIsqrt3 = 18'd37837;
  localparam logic [17:0] Coef2Isq3  = 18'd75674;

  localparam logic [1:0] RegBandLower = 2'd0;
  localparam logic [1:0] RegBandUpper = 2'd1;
  localparam logic [1:0] RegThreshold = 2'd2;

  typedef struct packed {
    logic signed [15:0] alpha_current;
    logic signed [15:0] beta_current;
    logic signed [15:0] x_current;
    logic signed [15:0] y_current;
    logic signed [15:0] zero_seq_one;
    logic signed [15:0] zero_seq_two;
  } in_item_t;

  typedef struct packed {
    logic signed [15:0] index_one;
    logic signed [15:0] index_two;
    logic signed [15:0] index_three;
    logic signed [15:0] index_four;
    logic signed [15:0] index_five;
    logic signed [15:0] index_six;
    logic fault_one;
    logic fault_two;
    logic fault_three;
    logic fault_four;
    logic fault_five;
    logic fault_six;
  } out_item_t;

  typedef struct packed {
    logic [RemW-1:0]    rem;
    logic [MagW:0]      dvs;
    logic [DivBits-1:0] quo;
    logic               neg;
    logic               dz;
  } div_t;

  // Scale a raw sample by an unsigned Q2.16 coefficient.
  function automatic logic signed [SumW-1:0] mul_coef(input logic signed [15:0] v,
                                                      input logic [17:0] c);
    logic signed [SumW-1:0] vs;
    logic signed [SumW-1:0] cs;
    begin
      vs = SumW'(v);
      cs = $signed({{(SumW-18){1'b0}}, c});
      return vs * cs;
    end
  endfunction

endpackage

>>> rtl/core/sofd_in_if.sv
`timescale 1ns / 1ps
interface sofd_in_if;
  logic                valid;
  logic                ready;
  sofd_pkg::in_item_t  data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

>>> rtl/core/sofd_out_if.sv
`timescale 1ns / 1ps
interface sofd_out_if;
  logic                valid;
  logic                ready;
  sofd_pkg::out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

>>> rtl/core/six_phase_open_fault_detector_top.sv
`timescale 1ns / 1ps
// Six-phase open-phase fault detector.
// in_ch carries one transaction per sample of the six VSD current
// components (alpha, beta, x, y, z1, z2, signed Q3.12). out_ch returns one
// transaction per sample: six band-filtered fault indices (signed Q5.10,
// saturated) and six fault flags (index strictly above the threshold).
// The cfg port writes band_lower (0), band_upper (1) and fault_threshold (2);
// other indices are ignored. Write only while the pipeline is empty.
// Depth: 21 register stages. Throughput: one transaction per cycle, sustained
// while the receiver does not stall the output register.
// Depth is set by the quotient, which
// is formed one bit per stage in a 17-stage restoring divider per phase.
// Pipeline: input register, numerator/denominator, magnitude setup,
// 17 divide stages, sign/saturate/filter register.
// Reset (rst_n low, synchronous) empties the pipeline and loads the
// register defaults: band [0, 2.0], threshold 410.
// When the receiver stalls with a transaction in the output register, the
// whole pipeline holds in place; in_ch.ready drops only in that case.
module six_phase_open_fault_detector_top (
  input  logic                clk,
  input  logic                rst_n,
  sofd_in_if.sink             in_ch,
  sofd_out_if.source          out_ch,
  input  logic                cfg_we,
  input  logic [1:0]          cfg_idx,
  input  logic [15:0]         cfg_wdata
);

  localparam int NumStages = sofd_pkg::DivBits + 4;
  localparam int LastStage = NumStages - 1;

  logic signed [15:0] band_lower_r, band_upper_r, threshold_r;
  logic [NumStages-1:0] v_r;
  logic adv;

  sofd_pkg::in_item_t smp_r;
  logic signed [sofd_pkg::SumW-1:0] num_r [sofd_pkg::NumPhases];
  logic signed [sofd_pkg::SumW-1:0] den_r [sofd_pkg::NumPhases];
  logic signed [sofd_pkg::SumW-1:0] num_nxt [sofd_pkg::NumPhases];
  logic signed [sofd_pkg::SumW-1:0] den_nxt [sofd_pkg::NumPhases];
  sofd_pkg::div_t div_r [sofd_pkg::DivBits+1][sofd_pkg::NumPhases];
  logic signed [15:0] idx_nxt [sofd_pkg::NumPhases];
  logic               flt_nxt [sofd_pkg::NumPhases];
  sofd_pkg::out_item_t out_r;

  // Advance everything unless the output register is full and stalled.
  assign adv          = !v_r[LastStage] || out_ch.ready;
  assign in_ch.ready  = adv;
  assign out_ch.valid = v_r[LastStage];
  assign out_ch.data  = out_r;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      band_lower_r <= 16'sd0;
      band_upper_r <= 16'sd2048;
      threshold_r  <= 16'sd410;
    end else if (cfg_we) begin
      case (cfg_idx)
        sofd_pkg::RegBandLower: band_lower_r <= cfg_wdata;
        sofd_pkg::RegBandUpper: band_upper_r <= cfg_wdata;
        sofd_pkg::RegThreshold: threshold_r  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Valid bits travel with the data.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (adv) begin
      v_r <= {v_r[NumStages-2:0], in_ch.valid};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      smp_r <= in_ch.data;
    end
  end

  // Stage 1: numerators and denominators, exact in Q2.16 scale.
  always_comb begin
    num_nxt[0] = -sofd_pkg::mul_coef(smp_r.x_current, sofd_pkg::CoefOne);
    den_nxt[0] = sofd_pkg::mul_coef(smp_r.alpha_current, sofd_pkg::CoefOne)
               + sofd_pkg::mul_coef(smp_r.zero_seq_one, sofd_pkg::CoefOne);
    num_nxt[1] = sofd_pkg::mul_coef(smp_r.x_current, sofd_pkg::CoefOne)
               + sofd_pkg::mul_coef(smp_r.y_current, sofd_pkg::CoefSqrt3)
               - sofd_pkg::mul_coef(smp_r.zero_seq_one, sofd_pkg::CoefTwo);
    den_nxt[1] = sofd_pkg::mul_coef(smp_r.beta_current, sofd_pkg::CoefSqrt3)
               - sofd_pkg::mul_coef(smp_r.alpha_current, sofd_pkg::CoefOne);
    num_nxt[2] = sofd_pkg::mul_coef(smp_r.x_current, sofd_pkg::CoefOne)
               - sofd_pkg::mul_coef(smp_r.y_current, sofd_pkg::CoefSqrt3)
               - sofd_pkg::mul_coef(smp_r.zero_seq_one, sofd_pkg::CoefTwo);
    den_nxt[2] = -sofd_pkg::mul_coef(smp_r.alpha_current, sofd_pkg::CoefOne)
               - sofd_pkg::mul_coef(smp_r.beta_current, sofd_pkg::CoefSqrt3);
    num_nxt[3] = sofd_pkg::mul_coef(smp_r.x_current, sofd_pkg::CoefOne)
               - sofd_pkg::mul_coef(smp_r.y_current, sofd_pkg::CoefIsqrt3)
               - sofd_pkg::mul_coef(smp_r.zero_seq_two, sofd_pkg::Coef2Isq3);
    den_nxt[3] = sofd_pkg::mul_coef(smp_r.alpha_current, sofd_pkg::CoefOne)
               + sofd_pkg::mul_coef(smp_r.beta_current, sofd_pkg::CoefIsqrt3);
    num_nxt[4] = sofd_pkg::mul_coef(smp_r.x_current, sofd_pkg::CoefOne)
               + sofd_pkg::mul_coef(smp_r.y_current, sofd_pkg::CoefIsqrt3)
               + sofd_pkg::mul_coef(smp_r.zero_seq_two, sofd_pkg::Coef2Isq3);
    den_nxt[4] = sofd_pkg::mul_coef(smp_r.alpha_current, sofd_pkg::CoefOne)
               - sofd_pkg::mul_coef(smp_r.beta_current, sofd_pkg::CoefIsqrt3);
    num_nxt[5] = -sofd_pkg::mul_coef(smp_r.y_current, sofd_pkg::CoefOne);
    den_nxt[5] = sofd_pkg::mul_coef(smp_r.beta_current, sofd_pkg::CoefOne)
               - sofd_pkg::mul_coef(smp_r.zero_seq_two, sofd_pkg::CoefOne);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      num_r <= num_nxt;
      den_r <= den_nxt;
    end
  end

  // Stage 2 and divide stages, one lane per phase.
  for (genvar p = 0; p < sofd_pkg::NumPhases; p++) begin : g_lane
    logic [sofd_pkg::MagW-1:0] an, ad;
    sofd_pkg::div_t setup_nxt;

    always_comb begin
      an = num_r[p][sofd_pkg::SumW-1] ? sofd_pkg::MagW'(-num_r[p])
                                      : sofd_pkg::MagW'(num_r[p]);
      ad = den_r[p][sofd_pkg::SumW-1] ? sofd_pkg::MagW'(-den_r[p])
                                      : sofd_pkg::MagW'(den_r[p]);
      // Dividend n*2048 + d, divisor 2d: rounds to nearest, ties away.
      setup_nxt.rem = {2'b00, an, 11'd0} + sofd_pkg::RemW'(ad);
      setup_nxt.dvs = {ad, 1'b0};
      setup_nxt.quo = '0;
      setup_nxt.neg = num_r[p][sofd_pkg::SumW-1] ^ den_r[p][sofd_pkg::SumW-1];
      setup_nxt.dz  = (den_r[p] == '0);
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        div_r[0][p] <= setup_nxt;
      end
    end

    // Stage j decides quotient bit DivBits-1-j. The top bit only flags
    // overflow; later bits do not matter then since the result saturates.
    for (genvar j = 0; j < sofd_pkg::DivBits; j++) begin : g_div
      localparam int Sh = sofd_pkg::DivBits - 1 - j;
      logic [sofd_pkg::CmpW-1:0] rem_w, sub_w;
      logic                      take;
      sofd_pkg::div_t            stg_nxt;

      always_comb begin
        rem_w   = sofd_pkg::CmpW'(div_r[j][p].rem);
        sub_w   = sofd_pkg::CmpW'(div_r[j][p].dvs) << Sh;
        take    = (rem_w >= sub_w);
        stg_nxt = div_r[j][p];
        if (take) begin
          stg_nxt.rem = sofd_pkg::RemW'(rem_w - sub_w);
          stg_nxt.quo[Sh] = 1'b1;
        end
      end

      always_ff @(posedge clk) begin
        if (adv) begin
          div_r[j+1][p] <= stg_nxt;
        end
      end
    end

    // Final: sign, saturate, band filter, threshold.
    logic [sofd_pkg::DivBits-1:0] q;
    logic signed [15:0] raw;
    always_comb begin
      q = div_r[sofd_pkg::DivBits][p].quo;
      if (div_r[sofd_pkg::DivBits][p].dz) begin
        raw = 16'sd0;
      end else if (div_r[sofd_pkg::DivBits][p].neg) begin
        raw = (q >= sofd_pkg::DivBits'(32768)) ? 16'sh8000 : 16'(-q);
      end else begin
        raw = (q >= sofd_pkg::DivBits'(32767)) ? 16'sh7fff : 16'(q);
      end
      idx_nxt[p] = (raw > band_upper_r || raw < band_lower_r) ? 16'sd0 : raw;
      flt_nxt[p] = (idx_nxt[p] > threshold_r);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_r.index_one   <= idx_nxt[0];
      out_r.index_two   <= idx_nxt[1];
      out_r.index_three <= idx_nxt[2];
      out_r.index_four  <= idx_nxt[3];
      out_r.index_five  <= idx_nxt[4];
      out_r.index_six   <= idx_nxt[5];
      out_r.fault_one   <= flt_nxt[0];
      out_r.fault_two   <= flt_nxt[1];
      out_r.fault_three <= flt_nxt[2];
      out_r.fault_four  <= flt_nxt[3];
      out_r.fault_five  <= flt_nxt[4];
      out_r.fault_six   <= flt_nxt[5];
    end
  end

`ifndef SYNTHESIS
  // An accepted transaction enters the first stage.
  a_enter: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.valid && in_ch.ready |=> v_r[0])
    else $error("accepted transaction not captured");

  // A kept nonzero index of phase one lies inside the band.
  a_band: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_r.index_one != 16'sd0 |->
      out_r.index_one >= band_lower_r && out_r.index_one <= band_upper_r)
    else $error("index outside band");

  // The fourth fault flag is raised only with its index above threshold.
  a_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_r.fault_four |-> out_r.index_four > threshold_r)
    else $error("fault flag without index above threshold");
`endif

endmodule
